[design/rsq_pkg.sv]
package rsq_pkg;

  // Angle reduction and sine table geometry.
  localparam int ANGLE_STEPS    = 360;
  localparam int QUARTER        = ANGLE_STEPS / 4;
  localparam int HALF_TURN      = ANGLE_STEPS / 2;
  localparam int IDX_W          = $clog2(ANGLE_STEPS);
  localparam int REM_W          = IDX_W + 1;

  // Fixed-point format of the sine table and the position arithmetic.
  localparam int SINE_FRAC_BITS = 14;
  localparam int SIN_W          = SINE_FRAC_BITS + 2;
  localparam int ROM_SH         = 30 - SINE_FRAC_BITS;
  localparam int UP_SH          = (SINE_FRAC_BITS < 14) ? (14 - SINE_FRAC_BITS) : 0;
  localparam int DN_SH          = (SINE_FRAC_BITS > 14) ? (SINE_FRAC_BITS - 14) : 0;
  localparam int OFS_W          = 12;
  localparam int PROD_W         = SIN_W + OFS_W;
  localparam int SUM_W          = SINE_FRAC_BITS + 18;
  localparam int QW             = SUM_W + UP_SH;
  localparam int SAT_W          = (QW + 1 > 33) ? (QW + 1) : 33;

  // The angle is biased to a positive value and divided by means of a reciprocal.
  localparam int ANG_V_W        = 17;
  localparam int ANG_BIAS       = (32768 / ANGLE_STEPS + 1) * ANGLE_STEPS;
  localparam int RECIP_SH       = 25;
  localparam int RECIP          = (1 << RECIP_SH) / ANGLE_STEPS;
  localparam int PRODQ_W        = 2 * ANG_V_W;
  localparam int QUO_W          = PRODQ_W - RECIP_SH;
  localparam int DIFF_W         = ANG_V_W + 1;

  // Output sequencing.
  localparam int CORNERS        = 4;
  localparam int BEATS          = 6;
  localparam int BEAT_W         = $clog2(BEATS);
  localparam int UV_W           = 25;
  localparam logic [23:0] WHITE = 24'hFFFFFF;

  // Sprite data that travels alongside the angle through the pipeline.
  typedef struct packed {
    logic signed [15:0]      center_x;
    logic signed [15:0]      center_y;
    logic signed [OFS_W-1:0] lo;
    logic signed [OFS_W-1:0] hi;
    logic [7:0]              alpha;
    logic [UV_W-1:0]         u0;
    logic [UV_W-1:0]         v0;
    logic [UV_W-1:0]         u1;
    logic [UV_W-1:0]         v1;
  } rsq_geom_t;

  // The four finished corners of one sprite.
  typedef struct packed {
    logic [CORNERS-1:0][31:0]     px;
    logic [CORNERS-1:0][31:0]     py;
    logic [CORNERS-1:0][UV_W-1:0] pu;
    logic [CORNERS-1:0][UV_W-1:0] pv;
    logic [7:0]                   alpha;
  } rsq_quad_t;

endpackage

[design/rsq_trig.sv]
module rsq_trig
  import rsq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_angle_deg,
  input  logic signed [15:0]      in_center_x,
  input  logic signed [15:0]      in_center_y,
  input  logic [11:0]             in_sprite_size,
  input  logic [7:0]              in_alpha,
  input  logic [23:0]             in_tex_u,
  input  logic [23:0]             in_tex_v,
  input  logic [23:0]             in_tex_span,
  output logic                    t_valid,
  input  logic                    t_ready,
  output logic signed [SIN_W-1:0] t_sin,
  output logic signed [SIN_W-1:0] t_cos,
  output rsq_geom_t               t_geom
);

  typedef logic [ANGLE_STEPS-1:0][SIN_W-1:0] sine_tab_t;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_TURN_W = 64'(HALF_TURN);
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Sine of the first quarter by a Taylor series in Q30, rounded to the table format.
  function automatic logic [63:0] quarter_sine(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    if (k >= 64'(QUARTER)) begin
      return 64'd1 << SINE_FRAC_BITS;
    end
    x    = (k * PI_Q30 + 64'(QUARTER)) / HALF_TURN_W;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return (acc + ((64'd1 << ROM_SH) >> 1)) >> ROM_SH;
  endfunction

  // Full-turn table built from the first quarter by symmetry.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t        tab;
    logic [63:0]      val;
    logic [SIN_W-1:0] mag;
    logic             neg;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      if (k <= QUARTER) begin
        val = quarter_sine(64'(k));
        neg = 1'b0;
      end else if (k <= 2 * QUARTER) begin
        val = quarter_sine(64'(2 * QUARTER - k));
        neg = 1'b0;
      end else if (k <= 3 * QUARTER) begin
        val = quarter_sine(64'(k - 2 * QUARTER));
        neg = 1'b1;
      end else begin
        val = quarter_sine(64'(ANGLE_STEPS - k));
        neg = 1'b1;
      end
      mag    = val[SIN_W-1:0];
      tab[k] = neg ? (~mag + 1'b1) : mag;
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic                   s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic                   s1_adv, s2_adv, s3_adv, s4_adv;
  logic [ANG_V_W-1:0]     v1_r, v1_nxt, v2_r;
  logic [PRODQ_W-1:0]     prod_r, prod_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic signed [SIN_W-1:0] sin_r, sin_nxt, cos_r, cos_nxt;
  rsq_geom_t              g1_r, g1_nxt, g2_r, g3_r, g4_r;
  logic [QUO_W-1:0]       quo;
  logic [DIFF_W-1:0]      diff;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_fix;
  logic [REM_W-1:0]       cidx_sum;
  logic [REM_W-1:0]       cidx_fix;
  logic [IDX_W-1:0]       cidx;
  logic [11:0]            half;

  // A stage takes new data when it is empty or its content moves on.
  assign s4_adv   = !s4_vld_r || t_ready;
  assign s3_adv   = !s3_vld_r || s4_adv;
  assign s2_adv   = !s2_vld_r || s3_adv;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_stall = !s1_adv;

  // Stage one: bias the angle positive and form the corner offsets and texture ends.
  always_comb begin
    half            = {1'b0, in_sprite_size[11:1]};
    v1_nxt          = ANG_V_W'(in_angle_deg) + ANG_V_W'(ANG_BIAS);
    g1_nxt.center_x = in_center_x;
    g1_nxt.center_y = in_center_y;
    g1_nxt.lo       = -$signed(half);
    g1_nxt.hi       = $signed(half) - 12'sd1;
    g1_nxt.alpha    = in_alpha;
    g1_nxt.u0       = UV_W'(in_tex_u);
    g1_nxt.v0       = UV_W'(in_tex_v);
    g1_nxt.u1       = UV_W'(in_tex_u) + UV_W'(in_tex_span);
    g1_nxt.v1       = UV_W'(in_tex_v) + UV_W'(in_tex_span);
  end

  // Stage two: quotient estimate by the reciprocal of the turn length.
  assign prod_nxt = PRODQ_W'(v1_r) * PRODQ_W'(RECIP);

  // Stage three: remainder, corrected once since the estimate is at most one low.
  always_comb begin
    quo     = prod_r[RECIP_SH +: QUO_W];
    diff    = DIFF_W'(v2_r) - DIFF_W'(quo) * DIFF_W'(ANGLE_STEPS);
    rem     = diff[REM_W-1:0];
    rem_fix = (rem >= REM_W'(ANGLE_STEPS)) ? (rem - REM_W'(ANGLE_STEPS)) : rem;
    idx_nxt = rem_fix[IDX_W-1:0];
  end

  // Stage four: sine at the angle and cosine a quarter turn on.
  always_comb begin
    cidx_sum = REM_W'(idx_r) + REM_W'(QUARTER);
    cidx_fix = (cidx_sum >= REM_W'(ANGLE_STEPS)) ?
               (cidx_sum - REM_W'(ANGLE_STEPS)) : cidx_sum;
    cidx     = cidx_fix[IDX_W-1:0];
    sin_nxt  = $signed(SINE_TAB[idx_r]);
    cos_nxt  = $signed(SINE_TAB[cidx]);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_valid;
      if (s2_adv) s2_vld_r <= s1_vld_r;
      if (s3_adv) s3_vld_r <= s2_vld_r;
      if (s4_adv) s4_vld_r <= s3_vld_r;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      v1_r <= v1_nxt;
      g1_r <= g1_nxt;
    end
    if (s2_adv) begin
      prod_r <= prod_nxt;
      v2_r   <= v1_r;
      g2_r   <= g1_r;
    end
    if (s3_adv) begin
      idx_r <= idx_nxt;
      g3_r  <= g2_r;
    end
    if (s4_adv) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
      g4_r  <= g3_r;
    end
  end

  assign t_valid = s4_vld_r;
  assign t_sin   = sin_r;
  assign t_cos   = cos_r;
  assign t_geom  = g4_r;

endmodule

[design/rsq_rotate.sv]
module rsq_rotate
  import rsq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    t_valid,
  output logic                    t_ready,
  input  logic signed [SIN_W-1:0] t_sin,
  input  logic signed [SIN_W-1:0] t_cos,
  input  rsq_geom_t               t_geom,
  output logic                    q_valid,
  input  logic                    q_ready,
  output rsq_quad_t               q_data
);

  localparam int RND = (1 << DN_SH) >> 1;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sd2147483648);

  // Scale to Q14 with round half up, then clamp to 32 bits.
  function automatic logic [31:0] to_q14(input logic signed [SUM_W-1:0] v);
    logic signed [SAT_W-1:0] w;
    w = (SAT_W'(v) <<< UP_SH) + SAT_W'(RND);
    w = w >>> DN_SH;
    if (w > SAT_MAX) begin
      return 32'h7FFFFFFF;
    end
    if (w < SAT_MIN) begin
      return 32'h80000000;
    end
    return w[31:0];
  endfunction

  logic                     r1_vld_r, r2_vld_r;
  logic                     r1_adv, r2_adv;
  logic signed [PROD_W-1:0] slo_r, shi_r, clo_r, chi_r;
  logic signed [SUM_W-1:0]  cx_r, cy_r;
  rsq_geom_t                g1_r;
  rsq_quad_t                quad_r, quad_nxt;

  assign r2_adv  = !r2_vld_r || q_ready;
  assign r1_adv  = !r1_vld_r || r2_adv;
  assign t_ready = r1_adv;

  // Final sums per corner: x = cx + s*b + c*a, y = cy - s*a + c*b.
  always_comb begin
    quad_nxt.px[0] = to_q14(cx_r + SUM_W'(slo_r) + SUM_W'(clo_r));
    quad_nxt.py[0] = to_q14(cy_r - SUM_W'(slo_r) + SUM_W'(clo_r));
    quad_nxt.px[1] = to_q14(cx_r + SUM_W'(slo_r) + SUM_W'(chi_r));
    quad_nxt.py[1] = to_q14(cy_r - SUM_W'(shi_r) + SUM_W'(clo_r));
    quad_nxt.px[2] = to_q14(cx_r + SUM_W'(shi_r) + SUM_W'(chi_r));
    quad_nxt.py[2] = to_q14(cy_r - SUM_W'(shi_r) + SUM_W'(chi_r));
    quad_nxt.px[3] = to_q14(cx_r + SUM_W'(shi_r) + SUM_W'(clo_r));
    quad_nxt.py[3] = to_q14(cy_r - SUM_W'(slo_r) + SUM_W'(chi_r));
    quad_nxt.pu[0] = g1_r.u0;
    quad_nxt.pu[1] = g1_r.u1;
    quad_nxt.pu[2] = g1_r.u1;
    quad_nxt.pu[3] = g1_r.u0;
    quad_nxt.pv[0] = g1_r.v0;
    quad_nxt.pv[1] = g1_r.v0;
    quad_nxt.pv[2] = g1_r.v1;
    quad_nxt.pv[3] = g1_r.v1;
    quad_nxt.alpha = g1_r.alpha;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
    end else begin
      if (r1_adv) r1_vld_r <= t_valid;
      if (r2_adv) r2_vld_r <= r1_vld_r;
    end
  end

  // Stage one holds the four products and the scaled centre; stage two the corners.
  always_ff @(posedge clk) begin
    if (r1_adv) begin
      slo_r <= PROD_W'(t_sin) * PROD_W'(t_geom.lo);
      shi_r <= PROD_W'(t_sin) * PROD_W'(t_geom.hi);
      clo_r <= PROD_W'(t_cos) * PROD_W'(t_geom.lo);
      chi_r <= PROD_W'(t_cos) * PROD_W'(t_geom.hi);
      cx_r  <= SUM_W'(t_geom.center_x) <<< SINE_FRAC_BITS;
      cy_r  <= SUM_W'(t_geom.center_y) <<< SINE_FRAC_BITS;
      g1_r  <= t_geom;
    end
    if (r2_adv) begin
      quad_r <= quad_nxt;
    end
  end

  assign q_valid = r2_vld_r;
  assign q_data  = quad_r;

endmodule

[design/rsq_emit.sv]
module rsq_emit
  import rsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  rsq_quad_t         q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [24:0]       out_vert_u,
  output logic [24:0]       out_vert_v,
  output logic [31:0]       out_color_argb,
  output logic              out_last_vertex
);

  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BEATS - 1);
  localparam logic [1:0] BEAT_CORNER [BEATS] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0};

  logic              vld_r, vld_nxt;
  logic [BEAT_W-1:0] cnt_r, cnt_nxt;
  rsq_quad_t         quad_r;
  logic              take, last, load;
  logic [1:0]        corner;

  // A sprite is loaded when the holder is empty or its last beat leaves.
  always_comb begin
    take    = vld_r && !out_stall;
    last    = (cnt_r == LAST_BEAT);
    q_ready = !vld_r || (take && last);
    load    = q_valid && q_ready;
    if (load) begin
      vld_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (take) begin
      vld_nxt = !last;
      cnt_nxt = last ? cnt_r : BEAT_W'(cnt_r + 1'b1);
    end else begin
      vld_nxt = vld_r;
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quad_r <= q_data;
    end
  end

  // Beat order c0, c1, c2, c2, c3, c0.
  always_comb begin
    corner          = BEAT_CORNER[cnt_r];
    out_valid       = vld_r;
    out_pos_x       = quad_r.px[corner];
    out_pos_y       = quad_r.py[corner];
    out_vert_u      = quad_r.pu[corner];
    out_vert_v      = quad_r.pv[corner];
    out_color_argb  = {quad_r.alpha, WHITE};
    out_last_vertex = last;
  end

`ifndef SYNTH
  // A stalled beat keeps its place in the sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(cnt_r)))
    else $error("stalled vertex beat moved");

  // A taken beat that is not the last moves to the next vertex.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_vertex) |=>
      (out_valid && cnt_r == BEAT_W'($past(cnt_r) + 1'b1)))
    else $error("vertex beat skipped or repeated");

  // After the last beat with nothing waiting, the channel goes quiet.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_vertex && !q_valid) |=> !out_valid)
    else $error("beat invented after last vertex");

  // A newly loaded sprite always starts at its first vertex.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |=> (out_valid && cnt_r == '0))
    else $error("new sprite did not start at first vertex");
`endif

endmodule

[design/rotated_sprite_quad_setup.sv]
// Channel   Handshake            Payload
// in_       in_valid / in_stall  angle, centre, size, alpha, texture origin and span
// out_      out_valid/out_stall  one vertex: position, texture u/v, colour, last flag
//
// A sprite passes four angle/lookup stages and two rotation stages, then
// produces six output beats, one per cycle while out_stall is low.
// A new sprite can enter every cycle while in_stall is low; the sustained
// rate is bounded by the single output channel carrying six vertices each.
// rst_n is synchronous and clears only valid bits and the beat counter.
// A stall on the output holds every stage that is full; nothing is dropped.
module rotated_sprite_quad_setup
  import rsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_angle_deg,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic [11:0]        in_sprite_size,
  input  logic [7:0]         in_alpha,
  input  logic [23:0]        in_tex_u,
  input  logic [23:0]        in_tex_v,
  input  logic [23:0]        in_tex_span,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [24:0]        out_vert_u,
  output logic [24:0]        out_vert_v,
  output logic [31:0]        out_color_argb,
  output logic               out_last_vertex
);

  logic                    t_valid, t_ready;
  logic signed [SIN_W-1:0] t_sin, t_cos;
  rsq_geom_t               t_geom;
  logic                    q_valid, q_ready;
  rsq_quad_t               q_data;

  // Angle reduction and sine/cosine lookup.
  rsq_trig u_trig (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_angle_deg   (in_angle_deg),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_sprite_size (in_sprite_size),
    .in_alpha       (in_alpha),
    .in_tex_u       (in_tex_u),
    .in_tex_v       (in_tex_v),
    .in_tex_span    (in_tex_span),
    .t_valid        (t_valid),
    .t_ready        (t_ready),
    .t_sin          (t_sin),
    .t_cos          (t_cos),
    .t_geom         (t_geom)
  );

  // Corner rotation about the centre.
  rsq_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .t_valid (t_valid),
    .t_ready (t_ready),
    .t_sin   (t_sin),
    .t_cos   (t_cos),
    .t_geom  (t_geom),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  // Six-beat vertex sequencer.
  rsq_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_vert_u      (out_vert_u),
    .out_vert_v      (out_vert_v),
    .out_color_argb  (out_color_argb),
    .out_last_vertex (out_last_vertex)
  );

endmodule
